### rtl/zpbws_pkg.sv
// ----------------------------------------------------------------------------
// zpbws_pkg
// Shared types and constants for the zero-padded box window sum block.
// ----------------------------------------------------------------------------
package zpbws_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int HALF_W     = 4;
  localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(1);
  localparam int HALF_LIMIT = 15;   // largest value the register can hold
  localparam int CMD_DEPTH  = 4;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_FLUSH,
    FS_RESUM
  } front_state_t;

  // One step for the accumulator: sum = (clr_sum ? 0 : sum) + add_val - sub_val
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] add_val;
    logic signed [SAMPLE_W-1:0] sub_val;
    logic                       clr_sum;
    logic                       emit;
    logic                       eos_final;
  } cmd_t;

endpackage

### rtl/zero_padded_box_window_sum_top.sv
// Each accepted sample queues a command in the FIFO; its result is then registered.
// Throughput: one sample per cycle while idle, no config pending and the FIFO has room.
// End of stream: min(samples_seen, h)+1 results; input is held off for all but the first.
// A half_width write starts a re-sum of window entries 0..2h, input held off meanwhile.
// Reset (synchronous, rst high): delay line, running sum and counters clear, half_width = 1.
// ----------------------------------------------------------------------------
// zero_padded_box_window_sum_top
// Zero-padded moving box sum over a stream of signed samples.
// ----------------------------------------------------------------------------
module zero_padded_box_window_sum_top #(
  parameter  int MAX_HALF_WIDTH = 15,
  localparam int LINE_DEPTH     = 2 * MAX_HALF_WIDTH + 1,
  localparam int SUM_W          = zpbws_pkg::SAMPLE_W + $clog2(LINE_DEPTH + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [zpbws_pkg::HALF_W-1:0]          cfg_data,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [zpbws_pkg::SAMPLE_W-1:0] sample,
  input  logic                                  end_of_stream,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [SUM_W-1:0]               window_sum,
  output logic                                  final_result
);

  zpbws_pkg::cmd_t cmd_in;
  zpbws_pkg::cmd_t cmd_out;
  logic            cmd_push;
  logic            cmd_full;
  logic            cmd_pop;
  logic            cmd_empty;

  zpbws_front #(
    .MAX_HALF_WIDTH(MAX_HALF_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .sample       (sample),
    .end_of_stream(end_of_stream),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  zpbws_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_data(cmd_in),
    .full_o (cmd_full),
    .rd_en  (cmd_pop),
    .rd_data(cmd_out),
    .empty_o(cmd_empty)
  );

  zpbws_back #(
    .SUM_W(SUM_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_empty   (cmd_empty),
    .cmd         (cmd_out),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .window_sum  (window_sum),
    .final_result(final_result)
  );

  // a config transaction starts the re-sum pass, which holds off samples
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> full)
    else $error("sample input open during window re-sum");

  // the command closing a stream returns the sequencer to idle
  a_final_cmd_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && cmd_in.eos_final) |=> cfg_ready)
    else $error("sequencer busy after end-of-stream command");

  // a mid-stream sample never starts a flush or re-sum
  a_normal_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !end_of_stream) |=> cfg_ready)
    else $error("sequencer left idle on a mid-stream sample");

  // every accepted sample issues exactly one command
  a_sample_issues_cmd: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |-> (cmd_push && !cmd_full))
    else $error("accepted sample issued no command");

endmodule

### rtl/zpbws_cmd_fifo.sv
// ----------------------------------------------------------------------------
// zpbws_cmd_fifo
// Short command queue between the front sequencer and the accumulator.
// ----------------------------------------------------------------------------
module zpbws_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  zpbws_pkg::cmd_t wr_data,
  output logic            full_o,
  input  logic            rd_en,
  output zpbws_pkg::cmd_t rd_data,
  output logic            empty_o
);

  localparam int PW = (zpbws_pkg::CMD_DEPTH > 1) ? $clog2(zpbws_pkg::CMD_DEPTH) : 1;
  localparam int CW = $clog2(zpbws_pkg::CMD_DEPTH + 1);

  zpbws_pkg::cmd_t entries [zpbws_pkg::CMD_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full_o  = (count == CW'(zpbws_pkg::CMD_DEPTH));
  assign empty_o = (count == '0);
  assign do_wr   = wr_en && !full_o;
  assign do_rd   = rd_en && !empty_o;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(zpbws_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(zpbws_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/zpbws_front.sv
// ----------------------------------------------------------------------------
// zpbws_front
// Accepts samples, keeps the delay line and stream position, and issues
// accumulator commands: one per sample, a flush walk at end of stream and
// a window re-sum after a half-width write.
// ----------------------------------------------------------------------------
module zpbws_front #(
  parameter int MAX_HALF_WIDTH = 15
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [zpbws_pkg::HALF_W-1:0]       cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic signed [zpbws_pkg::SAMPLE_W-1:0] sample,
  input  logic                               end_of_stream,
  input  logic                               cmd_full,
  output logic                               cmd_push,
  output zpbws_pkg::cmd_t                    cmd
);

  localparam int LINE_DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int IW         = $clog2(LINE_DEPTH + 1);

  logic signed [zpbws_pkg::SAMPLE_W-1:0] line [LINE_DEPTH];
  logic [zpbws_pkg::HALF_W-1:0] half_width;
  zpbws_pkg::front_state_t      state;
  zpbws_pkg::front_state_t      state_next;
  logic [IW-1:0]                cnt;
  logic [IW-1:0]                cnt_next;
  logic [IW-1:0]                seen;
  logic [IW-1:0]                seen_next;
  logic [IW-1:0]                h;
  logic [IW-1:0]                top;
  logic [IW-1:0]                rd_addr;
  logic signed [zpbws_pkg::SAMPLE_W-1:0] line_rd;
  logic                         in_acc;
  logic                         cfg_wr;
  logic                         shift_en;
  logic                         clear_en;

  always_comb begin
    if ((MAX_HALF_WIDTH < zpbws_pkg::HALF_LIMIT) && (int'(half_width) > MAX_HALF_WIDTH)) begin
      h = IW'(MAX_HALF_WIDTH);
    end else begin
      h = IW'(half_width);
    end
  end

  assign top       = (seen < h) ? seen : h;
  assign cfg_ready = (state == zpbws_pkg::FS_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready;
  // a pending configuration write wins over a sample
  assign full      = !((state == zpbws_pkg::FS_IDLE) && !cmd_full && !cfg_valid);
  assign in_acc    = push && !full;
  assign line_rd   = line[rd_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= zpbws_pkg::FS_IDLE;
      cnt        <= '0;
      seen       <= '0;
      half_width <= zpbws_pkg::HALF_RESET;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      seen  <= seen_next;
      if (cfg_wr) begin
        half_width <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_en) begin
      for (int k = 0; k < LINE_DEPTH; k++) begin
        line[k] <= '0;
      end
    end else if (shift_en) begin
      line[0] <= sample;
      for (int k = 1; k < LINE_DEPTH; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    seen_next  = seen;
    rd_addr    = IW'(2) * h;
    cmd_push   = 1'b0;
    cmd        = '0;
    shift_en   = 1'b0;
    clear_en   = 1'b0;
    case (state)
      zpbws_pkg::FS_IDLE: begin
        if (cfg_wr) begin
          state_next = zpbws_pkg::FS_RESUM;
          cnt_next   = '0;
        end else if (in_acc) begin
          // entry 2h leaves the window as the new sample enters
          rd_addr       = IW'(2) * h;
          cmd.add_val   = sample;
          cmd.sub_val   = line_rd;
          cmd.emit      = end_of_stream || (seen >= h);
          cmd.eos_final = end_of_stream && (top == '0);
          cmd_push      = 1'b1;
          shift_en      = 1'b1;
          if (end_of_stream) begin
            seen_next = '0;
            if (top == '0) begin
              clear_en = 1'b1;
            end else begin
              state_next = zpbws_pkg::FS_FLUSH;
              cnt_next   = top;
            end
          end else if (seen != IW'(MAX_HALF_WIDTH)) begin
            seen_next = seen + 1'b1;
          end
        end
      end
      zpbws_pkg::FS_FLUSH: begin
        // window for the next position drops its oldest entry cnt+h
        rd_addr = cnt + h;
        if (!cmd_full) begin
          cmd.sub_val   = line_rd;
          cmd.emit      = 1'b1;
          cmd.eos_final = (cnt == IW'(1));
          cmd_push      = 1'b1;
          cnt_next      = cnt - 1'b1;
          if (cnt == IW'(1)) begin
            clear_en   = 1'b1;
            state_next = zpbws_pkg::FS_IDLE;
          end
        end
      end
      zpbws_pkg::FS_RESUM: begin
        // rebuild the running sum over entries 0..2h
        rd_addr = cnt;
        if (!cmd_full) begin
          cmd.add_val = line_rd;
          cmd.clr_sum = (cnt == '0);
          cmd_push    = 1'b1;
          if (cnt == IW'(2) * h) begin
            state_next = zpbws_pkg::FS_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = zpbws_pkg::FS_IDLE;
      end
    endcase
  end

endmodule

### rtl/zpbws_back.sv
// ----------------------------------------------------------------------------
// zpbws_back
// Running-sum accumulator; executes queued commands and holds one result
// in an output register.
// ----------------------------------------------------------------------------
module zpbws_back #(
  parameter int SUM_W = 37
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_empty,
  input  zpbws_pkg::cmd_t         cmd,
  output logic                    cmd_pop,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [SUM_W-1:0] window_sum,
  output logic                    final_result
);

  localparam int EXT_W = SUM_W - zpbws_pkg::SAMPLE_W;

  logic signed [SUM_W-1:0] run_sum;
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] sum_next;
  logic                    out_valid;
  logic                    out_pop;

  assign empty   = !out_valid;
  assign out_pop = pop && out_valid;
  // a command that emits needs the output register free or draining
  assign cmd_pop = !cmd_empty && (!cmd.emit || !out_valid || pop);

  assign base     = cmd.clr_sum ? '0 : run_sum;
  assign sum_next = base
                  + {{EXT_W{cmd.add_val[zpbws_pkg::SAMPLE_W-1]}}, cmd.add_val}
                  - {{EXT_W{cmd.sub_val[zpbws_pkg::SAMPLE_W-1]}}, cmd.sub_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        run_sum <= cmd.eos_final ? '0 : sum_next;
      end
      if (cmd_pop && cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.emit) begin
      window_sum   <= sum_next;
      final_result <= cmd.eos_final;
    end
  end

endmodule

### test/tb_zero_padded_box_window_sum_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zero_padded_box_window_sum_top
// Self-checking bench for the zero-padded moving box sum. Samples go in
// through the push/full side, and a scoreboard holds the window sums that a
// behavioral copy of the filter predicts. Every popped result is compared
// against the oldest prediction. Runs directed corner streams, random
// streams at several half widths, a long output stall, and a gap-free tail.
// ----------------------------------------------------------------------------
module tb_zero_padded_box_window_sum_top;

  localparam int MAX_HALF   = 15;
  localparam int LINE_DEPTH = 2 * MAX_HALF + 1;
  localparam int SUM_W      = zpbws_pkg::SAMPLE_W + $clog2(LINE_DEPTH + 1);
  localparam int SEEN_MAX   = 31;
  // covers the re-sum after a half_width write plus the output latency
  localparam int SETTLE     = 2 * MAX_HALF + 10;

  localparam logic signed [zpbws_pkg::SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [zpbws_pkg::SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic                    fin;
  } window_result_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [zpbws_pkg::HALF_W-1:0]          cfg_data = '0;
  logic                                  push = 1'b0;
  logic                                  full;
  logic signed [zpbws_pkg::SAMPLE_W-1:0] sample = '0;
  logic                                  end_of_stream = 1'b0;
  logic                                  empty;
  logic                                  pop = 1'b0;
  logic signed [SUM_W-1:0]               window_sum;
  logic                                  final_result;

  // filter state mirrored by the bench
  logic signed [zpbws_pkg::SAMPLE_W-1:0] tap_line [LINE_DEPTH];
  int                                    seen_count = 0;
  int                                    half_now = 1;
  window_result_t                        pending_sums [$];

  int mismatch_count = 0;
  int items_sent = 0;
  bit tx_jitter = 1'b0;
  bit rx_jitter = 1'b0;
  int rx_hold_req = 0;

  zero_padded_box_window_sum_top #(.MAX_HALF_WIDTH(MAX_HALF)) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .sample        (sample),
    .end_of_stream (end_of_stream),
    .empty         (empty),
    .pop           (pop),
    .window_sum    (window_sum),
    .final_result  (final_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [SUM_W-1:0] tap_sum(input int lo, input int hi);
    longint acc = 0;
    for (int k = lo; k <= hi && k < LINE_DEPTH; k++) acc += tap_line[k];
    return acc[SUM_W-1:0];
  endfunction

  task automatic predict_window_sums(input logic signed [zpbws_pkg::SAMPLE_W-1:0] s,
                                     input logic eos);
    int h;
    int prior_seen;
    int top;
    window_result_t r;
    h = half_now;
    prior_seen = seen_count;
    for (int k = LINE_DEPTH - 1; k > 0; k--) tap_line[k] = tap_line[k-1];
    tap_line[0] = s;
    if (!eos) begin
      if (prior_seen >= h) begin
        r.sum = tap_sum(0, 2 * h);
        r.fin = 1'b0;
        pending_sums.push_back(r);
      end
      seen_count = (prior_seen < SEEN_MAX) ? prior_seen + 1 : SEEN_MAX;
    end else begin
      // flush the owed positions, oldest first; o is the distance from the last
      top = (prior_seen < h) ? prior_seen : h;
      for (int o = top; o >= 0; o--) begin
        r.sum = tap_sum((o > h) ? o - h : 0, o + h);
        r.fin = (o == 0);
        pending_sums.push_back(r);
      end
      foreach (tap_line[k]) tap_line[k] = '0;
      seen_count = 0;
    end
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    window_result_t want;
    if (!rst && pop && !empty) begin
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result sum=%0d final=%0b",
                                  window_sum, final_result));
      end else begin
        want = pending_sums.pop_front();
        if (window_sum !== want.sum)
          report_mismatch($sformatf("window_sum got %0d want %0d", window_sum, want.sum));
        if (final_result !== want.fin)
          report_mismatch($sformatf("final_result got %0b want %0b", final_result, want.fin));
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    int n;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        pop <= 1'b0;
        n = rx_hold_req;
        rx_hold_req = 0;
      end else if (rx_jitter && $urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        n = $urandom_range(1, 16);
      end else begin
        pop <= 1'b1;
        n = rx_jitter ? $urandom_range(1, 16) : 1;
      end
      repeat (n) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- sender side
  task automatic send_sample(input logic signed [zpbws_pkg::SAMPLE_W-1:0] s, input logic eos);
    if (tx_jitter && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push          <= 1'b1;
    sample        <= s;
    end_of_stream <= eos;
    do @(posedge clk); while (full);
    predict_window_sums(s, eos);
    items_sent++;
  endtask

  // sender pause: stop offering and wait for every owed result
  task automatic drain_results();
    push <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_half_width(input int value);
    cfg_valid <= 1'b1;
    cfg_data  <= zpbws_pkg::HALF_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    half_now = value;
  endtask

  function automatic logic signed [zpbws_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return zpbws_pkg::SAMPLE_W'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_stream(input int len, input bit uniform);
    logic signed [zpbws_pkg::SAMPLE_W-1:0] fill;
    fill = $urandom_range(0, 1) ? S_MAX : S_MIN;
    for (int i = 0; i < len; i++)
      send_sample(uniform ? fill : pick_sample(), i == len - 1);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    // reset value of half_width (1) is used first
    send_sample(S_MAX, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sh5555_5555, 1'b0);
    send_sample(32'shAAAA_AAAA, 1'b1);
    send_sample(S_MIN, 1'b1);                 // one-sample stream
    drain_results();
    write_half_width(0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    drain_results();
    write_half_width(zpbws_pkg::HALF_LIMIT);
    send_sample(S_MAX, 1'b0);                 // stream shorter than the window
    send_sample(32'sd1, 1'b0);
    send_sample(S_MIN, 1'b1);
    drain_results();
    write_half_width(2);
    send_sample(32'sd10, 1'b0);
    send_sample(32'sd20, 1'b0);
    send_sample(32'sd30, 1'b0);
    send_sample(32'sd40, 1'b0);
    drain_results();
    write_half_width(1);                      // change in the middle of a stream
    send_sample(32'sd50, 1'b0);
    send_sample(32'sd60, 1'b1);
    drain_results();
  endtask

  task automatic test_random_streams(input int goal);
    int h;
    int len;
    int stop_at;
    stop_at = items_sent + goal;
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 4))
        0:       h = 0;
        1:       h = zpbws_pkg::HALF_LIMIT;
        default: h = $urandom_range(0, zpbws_pkg::HALF_LIMIT);
      endcase
      drain_results();
      write_half_width(h);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0) begin
          // same extreme throughout, long enough to fill the whole window at this half width
          send_stream($urandom_range(2 * h + 1, 40), 1'b1);
        end else begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                            : $urandom_range(1, 2 * h + 3);
          send_stream(len, 1'b0);
        end
      end
    end
    drain_results();
  endtask

  task automatic test_output_stall();
    write_half_width(0);
    rx_hold_req = 300;
    // every sample yields a result, so the block backs up onto its input
    send_stream(40, 1'b0);
    drain_results();
  endtask

  task automatic test_quiet_tail();
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    write_half_width(3);
    send_stream(20, 1'b0);
    send_stream(5, 1'b0);
    send_stream(15, 1'b0);
  endtask

  task automatic finish_run();
    int waited;
    push <= 1'b0;
    waited = 0;
    while (pending_sums.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    while (pending_sums.size() != 0) begin
      window_result_t lost;
      lost = pending_sums.pop_front();
      report_mismatch($sformatf("missing result sum=%0d final=%0b", lost.sum, lost.fin));
    end
  endtask

  initial begin
    foreach (tap_line[k]) tap_line[k] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_streams(170);
    test_output_stall();
    test_quiet_tail();
    finish_run();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### zero_padded_box_window_sum_top.f
rtl/zpbws_pkg.sv
rtl/zpbws_cmd_fifo.sv
rtl/zpbws_front.sv
rtl/zpbws_back.sv
rtl/zero_padded_box_window_sum_top.sv
test/tb_zero_padded_box_window_sum_top.sv
